FILE: sv/sfrc8_pkg.sv
// Shared types, constants and the CRC-8 step for the sync frame receiver.
`default_nettype none
package sfrc8_pkg;

	localparam int PAYLOAD_LEN_DEF = 16;
	localparam int PAYLOAD_LEN_MAX = 64;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// Configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
	localparam logic [1:0] REG_FIRST_SYNC  = 2'd1;
	localparam logic [1:0] REG_SECOND_SYNC = 2'd2;
	localparam int APB_ADDR_W = 4;

	// Request operation codes
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_REARM = 1'b1;

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_SYNC2,
		ST_SRC,
		ST_DST,
		ST_PAYLOAD,
		ST_CRC,
		ST_PRIME,
		ST_EMIT,
		ST_WAIT
	} sfrc8_state_t;

	typedef struct packed {
		logic clear;       // hunting byte: restart frame registers
		logic take_src;
		logic take_dst;
		logic take_pay;    // store payload byte, advance CRC and count
		logic emit_start;  // read first payload entry
		logic emit_adv;    // read next payload entry
	} sfrc8_cmd_t;

	typedef struct packed {
		logic sync1_hit;
		logic sync2_hit;
		logic pay_full;    // current payload byte is the last one
		logic frame_ok;    // CRC byte matches and frame is addressed to us
		logic emit_last;
	} sfrc8_stat_t;

	typedef struct packed {
		logic [7:0] own_address;
		logic [7:0] first_sync;
		logic [7:0] second_sync;
	} sfrc8_cfg_t;

	function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: sv/sfrc8_if.sv
// Request channel interfaces: received bytes in, payload bytes out.
`default_nettype none
interface sfrc8_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;

	modport source (output valid, operation, rx_byte, input ready);
	modport sink (input valid, operation, rx_byte, output ready);
endinterface

interface sfrc8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [5:0] byte_index;
	logic [7:0] sender_address;
	logic       last_byte;

	modport source (output valid, payload_byte, byte_index, sender_address, last_byte,
		input ready);
	modport sink (input valid, payload_byte, byte_index, sender_address, last_byte,
		output ready);
endinterface
`default_nettype wire

FILE: sv/sync_frame_receiver_crc8_unit.sv
// Top level of the sync frame receiver with CRC-8 check and APB registers.
//
// Usage notes:
// - in_ch carries one request per received byte (operation = 0) or a rearm
//   (operation = 1). out_ch carries one request per payload byte of a frame
//   that passed the CRC-8 (poly 0x31, MSB first, init 0) and address check.
// - A frame is: first sync, second sync, source, destination, PAYLOAD_LEN
//   payload bytes, CRC. in_ch.ready is high except while a payload run is
//   being read out.
// - After the CRC byte of a good frame, the ST_PRIME state primes the payload
//   store read, then one payload byte is offered per cycle while out_ch.ready
//   stays high. The store's single read port sets that rate.
// - A stall on out_ch holds the current byte; the next store read happens
//   only on a taken request. in_ch is held off until the last byte leaves.
// - After the run the block ignores received bytes until a rearm.
// - Reset (arst_n low) returns to hunting with the configuration and frame
//   registers at zero; the payload store is not reset. Registers own_address,
//   first_sync, second_sync at byte addresses 0, 4, 8; write only while idle.
`default_nettype none
module sync_frame_receiver_crc8_unit import sfrc8_pkg::*; #(
	parameter int PAYLOAD_LEN = PAYLOAD_LEN_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	sfrc8_in_if.sink                   in_ch,
	sfrc8_out_if.source                out_ch
);

	sfrc8_cfg_t  cfg_q;
	sfrc8_cmd_t  cmd;
	sfrc8_stat_t stat;
	logic        cfg_wr;
	logic [1:0]  reg_idx;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_OWN_ADDRESS: cfg_q.own_address <= pwdata[7:0];
				REG_FIRST_SYNC:  cfg_q.first_sync  <= pwdata[7:0];
				REG_SECOND_SYNC: cfg_q.second_sync <= pwdata[7:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_OWN_ADDRESS: prdata = {24'd0, cfg_q.own_address};
			REG_FIRST_SYNC:  prdata = {24'd0, cfg_q.first_sync};
			REG_SECOND_SYNC: prdata = {24'd0, cfg_q.second_sync};
			default:         prdata = '0;
		endcase
	end

	// Controller: hunt/sequence FSM and handshakes
	sfrc8_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.operation),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: CRC, frame fields, payload store
	sfrc8_dp #(
		.PAYLOAD_LEN(PAYLOAD_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.rx_byte       (in_ch.rx_byte),
		.cmd           (cmd),
		.stat          (stat),
		.payload_byte  (out_ch.payload_byte),
		.byte_index    (out_ch.byte_index),
		.sender_address(out_ch.sender_address)
	);

	// Final byte of the run is flagged from the read-out index
	assign out_ch.last_byte = stat.emit_last;

`ifndef ASSERT_OFF
	// Input is held off whenever a payload byte is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input ready while payload run active");

	// Run ends exactly after the last byte is taken
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.last_byte) |=> !out_ch.valid)
		else $error("payload run continued past last byte");

	// Index advances by one on each taken non-final byte
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.last_byte) |=>
		(out_ch.valid && out_ch.byte_index == $past(out_ch.byte_index) + 6'd1))
		else $error("byte index did not advance");
`endif

endmodule
`default_nettype wire

FILE: sv/sfrc8_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module sfrc8_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: sv/sfrc8_ctrl.sv
// Frame controller: sync hunt, field sequencing and payload emission.
`default_nettype none
module sfrc8_ctrl import sfrc8_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_op,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire sfrc8_stat_t stat,
	output sfrc8_cmd_t       cmd
);

	sfrc8_state_t state_q, state_d;
	logic in_fire, byte_fire, out_fire;

	assign in_ready  = (state_q != ST_PRIME) && (state_q != ST_EMIT);
	assign out_valid = (state_q == ST_EMIT);
	assign in_fire   = in_valid && in_ready;
	assign byte_fire = in_fire && (in_op == OP_BYTE);
	assign out_fire  = out_valid && out_ready;

	always_comb begin
		state_d = state_q;
		if (in_fire && (in_op == OP_REARM)) begin
			state_d = ST_HUNT;
		end else begin
			unique case (state_q)
				ST_HUNT: if (byte_fire) begin
					state_d = stat.sync1_hit ? ST_SYNC2 : ST_HUNT;
				end
				ST_SYNC2: if (byte_fire) begin
					state_d = stat.sync2_hit ? ST_SRC : ST_HUNT;
				end
				ST_SRC: if (byte_fire) begin
					state_d = ST_DST;
				end
				ST_DST: if (byte_fire) begin
					state_d = ST_PAYLOAD;
				end
				ST_PAYLOAD: if (byte_fire && stat.pay_full) begin
					state_d = ST_CRC;
				end
				ST_CRC: if (byte_fire) begin
					state_d = stat.frame_ok ? ST_PRIME : ST_HUNT;
				end
				ST_PRIME: state_d = ST_EMIT;
				ST_EMIT: if (out_fire && stat.emit_last) begin
					state_d = ST_WAIT;
				end
				ST_WAIT: state_d = ST_WAIT;
				default: state_d = ST_HUNT;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_HUNT:    cmd.clear      = byte_fire;
			ST_SRC:     cmd.take_src   = byte_fire;
			ST_DST:     cmd.take_dst   = byte_fire;
			ST_PAYLOAD: cmd.take_pay   = byte_fire;
			ST_PRIME:   cmd.emit_start = 1'b1;
			ST_EMIT:    cmd.emit_adv   = out_fire && !stat.emit_last;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: sv/sfrc8_dp.sv
// Frame datapath: CRC, address registers, payload store and read-out index.
`default_nettype none
module sfrc8_dp import sfrc8_pkg::*; #(
	parameter int PAYLOAD_LEN = PAYLOAD_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sfrc8_cfg_t  cfg,
	input  wire logic [7:0]  rx_byte,
	input  wire sfrc8_cmd_t  cmd,
	output sfrc8_stat_t      stat,
	output logic [7:0]       payload_byte,
	output logic [5:0]       byte_index,
	output logic [7:0]       sender_address
);

	localparam int AW = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
	localparam int CW = $clog2(PAYLOAD_LEN + 1);

	logic [7:0]    crc_q, sender_q, target_q, crc_next;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] idx_q, raddr;
	logic          re;

	assign crc_next = crc8_add(crc_q, rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			fill_q   <= '0;
			sender_q <= '0;
			target_q <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.clear) begin
				crc_q    <= '0;
				fill_q   <= '0;
				sender_q <= '0;
				target_q <= '0;
			end
			if (cmd.take_src) begin
				sender_q <= rx_byte;
				crc_q    <= crc_next;
			end
			if (cmd.take_dst) begin
				target_q <= rx_byte;
				crc_q    <= crc_next;
			end
			if (cmd.take_pay) begin
				crc_q  <= crc_next;
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.emit_start) begin
				idx_q <= '0;
			end else if (cmd.emit_adv) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	assign re    = cmd.emit_start || cmd.emit_adv;
	assign raddr = cmd.emit_start ? '0 : (idx_q + AW'(1));

	sfrc8_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_LEN)
	) u_store (
		.clk  (clk),
		.we   (cmd.take_pay),
		.waddr(fill_q[AW-1:0]),
		.wdata(rx_byte),
		.re   (re),
		.raddr(raddr),
		.rdata(payload_byte)
	);

	assign stat.sync1_hit = (rx_byte == cfg.first_sync);
	assign stat.sync2_hit = (rx_byte == cfg.second_sync);
	assign stat.pay_full  = (fill_q == CW'(PAYLOAD_LEN - 1));
	assign stat.frame_ok  = (target_q == cfg.own_address) && (rx_byte == crc_q);
	assign stat.emit_last = (idx_q == AW'(PAYLOAD_LEN - 1));

	assign byte_index     = 6'(idx_q);
	assign sender_address = sender_q;

endmodule
`default_nettype wire
